>>> rtl/rdc_pkg.sv
// rdc_pkg: shared constants and request/result types for range_descriptor_cache.
// No dependencies.
package rdc_pkg;

  localparam int unsigned Records    = 384;
  localparam int unsigned ArenaBytes = 24576;
  localparam int unsigned SmallMax   = 1024;
  localparam int unsigned LargeSize  = 2048;

  localparam int unsigned IdxW   = $clog2(Records);
  localparam int unsigned CntW   = $clog2(Records + 1);
  localparam int unsigned SlotW  = $clog2(ArenaBytes + 1);
  localparam int unsigned KLenW  = 12;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_DROP   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  localparam logic CFG_CACHE_EN = 1'b0;
  localparam logic CFG_LARGE_EN = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] name_hash;
    logic [31:0] rel_offset;
    logic [23:0] range_length;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [14:0] payload_offset;
    logic        stored;
    logic        bypassed;
    logic        recycled;
    logic [8:0]  records_in_use;
  } rsp_t;

endpackage

>>> rtl/range_descriptor_cache.sv
// range_descriptor_cache: top level, sequencer and record table memory.
// Depends on rdc_pkg.
//
// Use: requests enter on in_valid/in_stall, results leave on
// out_valid/out_stall, one result per request, in order. Registers are
// written on cfg_we with cfg_index 0 (cache enable) or 1 (large enable).
// One request is worked at a time; in_stall is high while busy and while a
// result waits. Lookup, fill and drop walk the record memory entry by entry
// over a single read port and a single compare unit:
//   lookup        : scans in order and stops at the first match
//   fill (small)  : finds the lowest large, appends if the request fits, else
//                   evicts that large and tries again, and with no large left
//                   recycles the table once before bypassing
//   fill (large)  : finds the lowest large and appends below it, or bypasses
//   drop large    : one pass compacting the table
//   clear         : empties the table
// The result sits in an output register; a stall there only holds it, and
// the next request can be taken in the cycle after it has been delivered.
// Reset (rst_n low, synchronous) empties the table and clears the control
// registers; no clearing pass is needed since only counted entries are read.
module range_descriptor_cache (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rdc_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output rdc_pkg::rsp_t out_rsp,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic          cfg_data
);
  import rdc_pkg::*;

  typedef struct packed {
    logic [31:0]      h;
    logic [31:0]      o;
    logic [KLenW-1:0] len;
    logic [SlotW-1:0] slot;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LK_RD, S_LK_CMP, S_LOW_RD, S_LOW_CMP, S_FILL_DEC,
    S_SHIFT_RD, S_SHIFT_WR, S_APPEND, S_DROP_RD, S_DROP_CMP, S_DONE
  } state_t;

  // Record memory, one write and one read port, registered read
  rec_t             mem [Records];
  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  rec_t             wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  state_t           state_r;
  req_t             req_r;
  logic             cache_en_r, large_en_r;
  logic [CntW-1:0]  count_r;
  logic [SlotW-1:0] used_r;
  logic [CntW-1:0]  i_r;      // scan pointer
  logic [CntW-1:0]  j_r;      // write pointer for compaction
  logic [SlotW-1:0] low_r;    // lowest large slot found
  logic [CntW-1:0]  vict_r;
  logic             found_r;
  logic             recyc_r;
  logic             out_valid_r;
  rsp_t             rsp_r;

  logic             small_w, large_w, is_large_rec, key_eq;
  logic [SlotW:0]   room;
  logic [IdxW-1:0]  i_idx;

  assign i_idx   = i_r[IdxW-1:0];
  assign small_w = cache_en_r && (req_r.range_length != 24'd0) &&
                   (req_r.range_length <= 24'(SmallMax));
  assign large_w = !small_w && cache_en_r && large_en_r &&
                   (req_r.range_length == 24'(LargeSize));
  assign is_large_rec = (rdata_r.len == KLenW'(LargeSize));
  assign key_eq = (rdata_r.h == req_r.name_hash) && (rdata_r.o == req_r.rel_offset) &&
                  ({12'd0, rdata_r.len} == req_r.range_length);
  // space between small region and lowest large range
  assign room = {1'b0, low_r} - {1'b0, used_r};

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // Memory port drive
  always_comb begin
    we    = 1'b0;
    waddr = j_r[IdxW-1:0];
    wdata = rdata_r;
    raddr = i_idx;
    case (state_r)
      S_SHIFT_WR: we = 1'b1;
      S_DROP_CMP: we = !is_large_rec;
      S_APPEND: begin
        we    = 1'b1;
        waddr = count_r[IdxW-1:0];
        wdata.h    = req_r.name_hash;
        wdata.o    = req_r.rel_offset;
        wdata.len  = req_r.range_length[KLenW-1:0];
        wdata.slot = small_w ? used_r : SlotW'(low_r - SlotW'(LargeSize));
      end
      default: ;
    endcase
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cache_en_r  <= 1'b0;
      large_en_r  <= 1'b0;
      count_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      recyc_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CACHE_EN) cache_en_r <= cfg_data;
        else                          large_en_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_r   <= in_req;
            rsp_r   <= '0;
            recyc_r <= 1'b0;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          i_r     <= '0;
          j_r     <= '0;
          low_r   <= SlotW'(ArenaBytes);
          found_r <= 1'b0;
          case (mode_t'(req_r.mode))
            MODE_LOOKUP: begin
              if (!small_w && !large_w) begin
                rsp_r.bypassed <= 1'b1;
                state_r <= S_DONE;
              end else state_r <= S_LK_RD;
            end
            MODE_FILL: begin
              if (!small_w && !large_w) begin
                rsp_r.bypassed <= 1'b1;
                state_r <= S_DONE;
              end else state_r <= S_LOW_RD;
            end
            MODE_DROP: state_r <= S_DROP_RD;
            default: begin
              count_r <= '0;
              used_r  <= '0;
              state_r <= S_DONE;
            end
          endcase
        end
        // Lookup scan: read, then compare
        S_LK_RD: state_r <= (i_r < count_r) ? S_LK_CMP : S_DONE;
        S_LK_CMP: begin
          if (key_eq) begin
            rsp_r.hit            <= 1'b1;
            rsp_r.payload_offset <= 15'(rdata_r.slot);
            state_r <= S_DONE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_LK_RD;
          end
        end
        // Lowest-large scan
        S_LOW_RD: state_r <= (i_r < count_r) ? S_LOW_CMP : S_FILL_DEC;
        S_LOW_CMP: begin
          if (is_large_rec && rdata_r.slot < low_r) begin
            low_r   <= rdata_r.slot;
            vict_r  <= i_r;
            found_r <= 1'b1;
          end
          i_r     <= i_r + 1'b1;
          state_r <= S_LOW_RD;
        end
        S_FILL_DEC: begin
          if (large_w) begin
            if (count_r >= CntW'(Records) || low_r < SlotW'(LargeSize) ||
                (low_r - SlotW'(LargeSize)) < used_r) begin
              rsp_r.bypassed <= 1'b1;
              state_r <= S_DONE;
            end else state_r <= S_APPEND;
          end else if (count_r < CntW'(Records) && !room[SlotW] &&
                       {1'b0, req_r.range_length} <= 25'(room)) begin
            state_r <= S_APPEND;
          end else if (found_r) begin
            // evict lowest large: shift entries above it down by one
            i_r     <= vict_r + 1'b1;
            j_r     <= vict_r;
            state_r <= S_SHIFT_RD;
          end else if (!recyc_r) begin
            recyc_r <= 1'b1;
            count_r <= '0;
            used_r  <= '0;
            i_r     <= '0;
            low_r   <= SlotW'(ArenaBytes);
            state_r <= S_LOW_RD;
          end else begin
            rsp_r.bypassed <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_SHIFT_RD: begin
          if (i_r < count_r) state_r <= S_SHIFT_WR;
          else begin
            count_r <= count_r - 1'b1;
            i_r     <= '0;
            j_r     <= '0;
            found_r <= 1'b0;
            low_r   <= SlotW'(ArenaBytes);
            state_r <= S_LOW_RD;
          end
        end
        S_SHIFT_WR: begin
          i_r     <= i_r + 1'b1;
          j_r     <= j_r + 1'b1;
          state_r <= S_SHIFT_RD;
        end
        S_APPEND: begin
          count_r              <= count_r + 1'b1;
          rsp_r.stored         <= 1'b1;
          rsp_r.payload_offset <= small_w ? 15'(used_r) : 15'(low_r - SlotW'(LargeSize));
          if (small_w) used_r  <= used_r + SlotW'(req_r.range_length);
          state_r <= S_DONE;
        end
        // Drop: compact non-large entries in place
        S_DROP_RD: begin
          if (i_r < count_r) state_r <= S_DROP_CMP;
          else begin
            count_r <= j_r;
            state_r <= S_DONE;
          end
        end
        S_DROP_CMP: begin
          if (!is_large_rec) j_r <= j_r + 1'b1;
          i_r     <= i_r + 1'b1;
          state_r <= S_DROP_RD;
        end
        S_DONE: begin
          rsp_r.recycled       <= recyc_r;
          rsp_r.records_in_use <= 9'(count_r);
          out_valid_r          <= 1'b1;
          state_r              <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Records)) else $error("record count over capacity");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(rsp_r))
    else $error("held result lost");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accept while busy");
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rsp_r.stored && rsp_r.bypassed))
    else $error("stored and bypassed together");
`endif

endmodule
